/* sv/binary_gap_fill_pulse_filter_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the gap-fill / pulse filter core
// Both macros expect signals named clk and rst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef BINARY_GAP_FILL_PULSE_FILTER_CORE_ASSERT_SVH
`define BINARY_GAP_FILL_PULSE_FILTER_CORE_ASSERT_SVH

// same-cycle implication
`define BGF_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BGF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/bgf_pkg.sv */
// ----------------------------------------------------------------------------
// bgf_pkg
// Types, constants and helper functions of the gap-fill / pulse filter.
// ----------------------------------------------------------------------------
package bgf_pkg;

    localparam int NUM_BINS    = 128;
    localparam int NUM_STREAMS = 2 * NUM_BINS;
    localparam int STREAM_W    = $clog2(NUM_STREAMS);
    localparam int BIN_W       = 7;
    localparam int LEN_W       = 5;
    localparam int MAX_MIN_LEN = 16;
    localparam int PEND_W      = $clog2(MAX_MIN_LEN);
    localparam int CNT_W       = $clog2(2 * MAX_MIN_LEN);
    localparam int STATE_W     = 2 * PEND_W + 2;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN_LEN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN_LEN = CFG_IDX_W'(1);

    typedef struct packed {
        logic             map_select;
        logic [BIN_W-1:0] bin_index;
        logic             active;
        logic             frame_last;
    } sample_t;

    typedef struct packed {
        logic             out_map;
        logic [BIN_W-1:0] out_bin;
        logic             filtered;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [PEND_W-1:0] zero_pend;
        logic              zero_conf;
        logic [PEND_W-1:0] one_pend;
        logic              one_conf;
    } stream_state_t;

    // run descriptor: lead_zeros zeros, then ones ones, then zeros up to total
    typedef struct packed {
        logic             out_map;
        logic [BIN_W-1:0] out_bin;
        logic [CNT_W-1:0] lead_zeros;
        logic [CNT_W-1:0] ones;
        logic [CNT_W-1:0] total;
    } desc_t;

    typedef struct packed {
        logic [CNT_W-1:0]  ones;
        logic [PEND_W-1:0] one_pend;
        logic              one_conf;
    } s2_t;

    // zero acts as one, anything above the maximum saturates
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > LEN_W'(MAX_MIN_LEN)) begin
            r = CNT_W'(MAX_MIN_LEN);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    // stage two fed with k one bits in a row
    function automatic s2_t s2_ones(input logic [PEND_W-1:0] op,
                                    input logic              oc,
                                    input logic [CNT_W-1:0]  k,
                                    input logic [CNT_W-1:0]  plen);
        logic [CNT_W-1:0] t;
        s2_t              r;
        t          = CNT_W'(op) + k;
        r.ones     = '0;
        r.one_pend = op;
        r.one_conf = oc;
        if (k != '0) begin
            if (oc) begin
                r.ones = k;
            end else if (t >= plen) begin
                r.ones     = t;
                r.one_pend = '0;
                r.one_conf = 1'b1;
            end else begin
                r.one_pend = t[PEND_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

/* sv/bgf_ram.sv */
// ----------------------------------------------------------------------------
// bgf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read during write to the same entry returns the old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/bgf_update.sv */
// ----------------------------------------------------------------------------
// bgf_update
// Per-sample stream update: new stream state and the run descriptor of the
// bits released by this sample.
// ----------------------------------------------------------------------------
module bgf_update (
    input  bgf_pkg::stream_state_t           state,
    input  bgf_pkg::sample_t                 sample,
    input  logic [bgf_pkg::CNT_W-1:0]        gap_len,
    input  logic [bgf_pkg::CNT_W-1:0]        pulse_len,
    output bgf_pkg::stream_state_t           state_next,
    output bgf_pkg::desc_t                   desc
);

    logic [bgf_pkg::CNT_W-1:0]  zp_inc;
    logic [bgf_pkg::CNT_W-1:0]  z1;
    logic [bgf_pkg::CNT_W-1:0]  o1;
    logic [bgf_pkg::CNT_W-1:0]  z2;
    logic [bgf_pkg::CNT_W-1:0]  ones_sum;
    logic [bgf_pkg::PEND_W-1:0] nzp;
    logic                       nzc;
    logic [bgf_pkg::PEND_W-1:0] nop;
    logic                       noc;
    bgf_pkg::s2_t               s2_run;
    bgf_pkg::s2_t               s2_flush;

    assign zp_inc   = bgf_pkg::CNT_W'(state.zero_pend) + bgf_pkg::CNT_W'(1);
    assign s2_run   = bgf_pkg::s2_ones(state.one_pend, state.one_conf, zp_inc, pulse_len);
    assign s2_flush = bgf_pkg::s2_ones(nop, noc, bgf_pkg::CNT_W'(nzp), pulse_len);

    // stage one, with stage two fed by what it releases
    always_comb
    begin
        z1  = '0;
        o1  = '0;
        nzp = state.zero_pend;
        nzc = state.zero_conf;
        nop = state.one_pend;
        noc = state.one_conf;
        if (!sample.active)
        begin
            if (state.zero_conf)
            begin
                z1  = bgf_pkg::CNT_W'(state.one_pend) + bgf_pkg::CNT_W'(1);
                nop = '0;
                noc = 1'b0;
            end
            else if (zp_inc >= gap_len)
            begin
                z1  = bgf_pkg::CNT_W'(state.one_pend) + zp_inc;
                nzp = '0;
                nzc = 1'b1;
                nop = '0;
                noc = 1'b0;
            end
            else
            begin
                nzp = zp_inc[bgf_pkg::PEND_W-1:0];
            end
        end
        else
        begin
            // held zeros were a short gap: they go on as ones
            nzp = '0;
            nzc = 1'b0;
            o1  = s2_run.ones;
            nop = s2_run.one_pend;
            noc = s2_run.one_conf;
        end
    end

    // frame end flushes held zeros as ones, then held ones as zeros
    always_comb
    begin
        if (sample.frame_last)
        begin
            ones_sum   = o1 + s2_flush.ones;
            z2         = bgf_pkg::CNT_W'(s2_flush.one_pend);
            state_next = '0;
        end
        else
        begin
            ones_sum             = o1;
            z2                   = '0;
            state_next.zero_pend = nzp;
            state_next.zero_conf = nzc;
            state_next.one_pend  = nop;
            state_next.one_conf  = noc;
        end
    end

    assign desc.out_map    = sample.map_select;
    assign desc.out_bin    = sample.bin_index;
    assign desc.lead_zeros = z1;
    assign desc.ones       = ones_sum;
    assign desc.total      = z1 + ones_sum + z2;

endmodule

/* sv/bgf_emitter.sv */
// ----------------------------------------------------------------------------
// bgf_emitter
// Plays one run descriptor out as result requests, one per unstalled cycle.
// ----------------------------------------------------------------------------
`include "binary_gap_fill_pulse_filter_core_assert.svh"

module bgf_emitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             desc_valid,
    input  bgf_pkg::desc_t   desc,
    output logic             desc_ready,
    output logic             result_valid,
    input  logic             result_stall,
    output bgf_pkg::result_t result
);

    logic                       busy_reg;
    logic                       map_reg;
    logic [bgf_pkg::BIN_W-1:0]  bin_reg;
    logic [bgf_pkg::CNT_W-1:0]  zeros_reg;
    logic [bgf_pkg::CNT_W-1:0]  ones_reg;
    logic [bgf_pkg::CNT_W-1:0]  total_reg;
    logic                       fire;
    logic                       final_one;
    logic                       load;

    assign fire       = busy_reg && !result_stall;
    assign final_one  = (total_reg == bgf_pkg::CNT_W'(1));
    assign desc_ready = !busy_reg || (fire && final_one);
    assign load       = desc_valid && desc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
        end
        else if (fire && final_one)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            map_reg   <= desc.out_map;
            bin_reg   <= desc.out_bin;
            zeros_reg <= desc.lead_zeros;
            ones_reg  <= desc.ones;
            total_reg <= desc.total;
        end
        else if (fire)
        begin
            total_reg <= total_reg - bgf_pkg::CNT_W'(1);
            if (zeros_reg != '0)
            begin
                zeros_reg <= zeros_reg - bgf_pkg::CNT_W'(1);
            end
            else if (ones_reg != '0)
            begin
                ones_reg <= ones_reg - bgf_pkg::CNT_W'(1);
            end
        end
    end

    assign result_valid    = busy_reg;
    assign result.out_map  = map_reg;
    assign result.out_bin  = bin_reg;
    assign result.filtered = (zeros_reg == '0) && (ones_reg != '0);
    assign result.last     = final_one;

    `BGF_ASSERT_NOW(a_busy_nonzero, busy_reg, total_reg != '0, "emitter busy with empty run")
    `BGF_ASSERT_NEXT(a_count_down, fire && !final_one && !load, busy_reg && (total_reg == $past(total_reg) - bgf_pkg::CNT_W'(1)), "result count did not step")
    `BGF_ASSERT_NEXT(a_load_busy, load, busy_reg && (total_reg == $past(desc.total)), "descriptor not taken")

endmodule

/* sv/binary_gap_fill_pulse_filter_core.sv */
// ----------------------------------------------------------------------------
// binary_gap_fill_pulse_filter_core
// Per-stream minimum run-length filter: zero gaps shorter than gap_min_len
// are closed to ones, then one pulses shorter than pulse_min_len are opened
// to zeros. A stream is (map_select, bin_index); its state lives in a
// 256-entry RAM that is read when a sample is taken, updated in the update
// stage and written back, with forwarding so samples of the same stream may
// follow each other in consecutive cycles. A new sample is taken every cycle
// as long as the output keeps up: a sample that releases n filtered bits (n
// from 0 to 31) holds the single output register for one result per bit, and
// that register at one result per unstalled cycle sets the throughput. The
// first result passes the read stage, update stage and emitter. Stream state
// is zero after reset through per-entry valid flags, so no clearing pass is
// needed. Length registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "binary_gap_fill_pulse_filter_core_assert.svh"

module binary_gap_fill_pulse_filter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  bgf_pkg::sample_t              sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output bgf_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bgf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bgf_pkg::LEN_W-1:0]     cfg_data
);

    // configuration
    logic [bgf_pkg::LEN_W-1:0]    gap_len_reg;
    logic [bgf_pkg::LEN_W-1:0]    pulse_len_reg;
    logic [bgf_pkg::CNT_W-1:0]    gap_eff;
    logic [bgf_pkg::CNT_W-1:0]    pulse_eff;

    // read stage
    logic                         a_valid_reg;
    bgf_pkg::sample_t             a_item_reg;
    logic [bgf_pkg::STREAM_W-1:0] a_idx_reg;
    logic                         a_mem_vld_reg;
    logic                         a_fwd_vld_reg;
    bgf_pkg::stream_state_t       a_fwd_data_reg;

    // update stage
    logic                         b_valid_reg;
    bgf_pkg::sample_t             b_item_reg;
    logic [bgf_pkg::STREAM_W-1:0] b_idx_reg;
    bgf_pkg::stream_state_t       b_state_reg;
    bgf_pkg::stream_state_t       b_state_next;

    logic [bgf_pkg::NUM_STREAMS-1:0] state_vld_reg;
    logic [bgf_pkg::STATE_W-1:0]     rd_data;
    bgf_pkg::stream_state_t          mem_state;

    logic [bgf_pkg::STREAM_W-1:0] in_idx;
    logic                         accept;
    logic                         a_advance;
    logic                         b_advance;
    logic                         b_free;
    logic                         a_free;
    logic                         wr_en;
    bgf_pkg::stream_state_t       wr_state;
    bgf_pkg::desc_t               desc;
    logic                         desc_ready;
    logic                         desc_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_len_reg   <= bgf_pkg::LEN_RESET;
            pulse_len_reg <= bgf_pkg::LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bgf_pkg::REG_GAP_MIN_LEN:   gap_len_reg   <= cfg_data;
                bgf_pkg::REG_PULSE_MIN_LEN: pulse_len_reg <= cfg_data;
            endcase
        end
    end

    assign gap_eff   = bgf_pkg::eff_len(gap_len_reg);
    assign pulse_eff = bgf_pkg::eff_len(pulse_len_reg);

    // stream index: map in the top bit, bin below it
    assign in_idx = bgf_pkg::STREAM_W'({sample.map_select, sample.bin_index});

    // zero-result samples never occupy the emitter
    assign desc_valid   = b_valid_reg && (desc.total != '0);
    assign b_advance    = b_valid_reg && ((desc.total == '0) || desc_ready);
    assign b_free       = !b_valid_reg || b_advance;
    assign a_advance    = a_valid_reg && b_free;
    assign a_free       = !a_valid_reg || a_advance;
    assign sample_stall = !a_free;
    assign accept       = sample_valid && a_free;

    assign wr_en    = b_advance;
    assign mem_state = bgf_pkg::stream_state_t'(rd_data);

    bgf_ram #(
        .WIDTH (bgf_pkg::STATE_W),
        .DEPTH (bgf_pkg::NUM_STREAMS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (b_idx_reg),
        .wr_data (wr_state),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            state_vld_reg[b_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_advance)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // a write-back that lands after the RAM read is caught here
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg     <= sample;
            a_idx_reg      <= in_idx;
            a_mem_vld_reg  <= state_vld_reg[in_idx];
            a_fwd_vld_reg  <= wr_en && (b_idx_reg == in_idx);
            a_fwd_data_reg <= wr_state;
        end
        else if (wr_en && (b_idx_reg == a_idx_reg))
        begin
            a_fwd_vld_reg  <= 1'b1;
            a_fwd_data_reg <= wr_state;
        end
    end

    always_comb
    begin
        priority if (wr_en && (b_idx_reg == a_idx_reg))
        begin
            b_state_next = wr_state;
        end
        else if (a_fwd_vld_reg)
        begin
            b_state_next = a_fwd_data_reg;
        end
        else if (a_mem_vld_reg)
        begin
            b_state_next = mem_state;
        end
        else
        begin
            b_state_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            b_item_reg  <= a_item_reg;
            b_idx_reg   <= a_idx_reg;
            b_state_reg <= b_state_next;
        end
    end

    bgf_update u_update (
        .state      (b_state_reg),
        .sample     (b_item_reg),
        .gap_len    (gap_eff),
        .pulse_len  (pulse_eff),
        .state_next (wr_state),
        .desc       (desc)
    );

    bgf_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc_valid   (desc_valid),
        .desc         (desc),
        .desc_ready   (desc_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `BGF_ASSERT_NEXT(a_fwd_capture, a_valid_reg && !a_advance && wr_en && (b_idx_reg == a_idx_reg), a_fwd_vld_reg && (a_fwd_data_reg == $past(wr_state)), "write-back missed by waiting sample")
    `BGF_ASSERT_NEXT(a_vld_set, wr_en, state_vld_reg[$past(b_idx_reg)], "stream valid flag not set after write-back")
    `BGF_ASSERT_NOW(a_b_hold_busy, b_valid_reg && !b_advance, result_valid, "update stage held with idle output")

endmodule

/* dv/binary_gap_fill_pulse_filter_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_gap_fill_pulse_filter_core_test
// Self-checking bench for the gap-fill / pulse filter. A queue-fed driver
// offers samples, a clocked predictor tracks each stream's held runs and
// builds the filtered bits every accepted sample releases, and a monitor
// compares every result against them in order. Phases vary the run-length
// registers and the idle/stall mix; one phase holds the output off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module binary_gap_fill_pulse_filter_core_test;

    import bgf_pkg::*;

    localparam int MAX_BURST    = 31;
    localparam int NUM_LANES    = 4;
    localparam int SETTLE_CYC   = 16;
    localparam int END_WAIT_CYC = 32;
    localparam int HOLD_CYC     = 300;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct {
        int unsigned zeros_held;
        bit          zero_run_ok;
        int unsigned ones_held;
        bit          one_run_ok;
    } run_track_t;

    // one well-formed stream being generated: current level and samples left
    typedef struct {
        logic             map;
        logic [BIN_W-1:0] bin;
        bit               level;
        int               left;
    } lane_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             sample_valid = 1'b0;
    logic             sample_stall;
    sample_t          sample       = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    result_t          result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0] cfg_data     = '0;

    // predictor state
    run_track_t       trk [NUM_STREAMS];
    logic [LEN_W-1:0] gap_len   = LEN_RESET;
    logic [LEN_W-1:0] pulse_len = LEN_RESET;
    logic             cur_map;
    logic [BIN_W-1:0] cur_bin;
    result_t          burst[$];
    result_t          filt_q[$];
    result_t          want;

    // stimulus
    sample_t          sample_q[$];
    sample_t          next_q[$];
    lane_t            lanes [NUM_LANES];
    int               idle_pct  = 0;
    int               stall_pct = 0;
    int               hold_ask  = 0;
    int               phase_num = 0;
    int               hold_phase = 0;
    int               hold_left = 0;
    int               quiet_cycles = 0;
    int               err_count = 0;

    binary_gap_fill_pulse_filter_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned clamp_len(logic [LEN_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > MAX_MIN_LEN)
        begin
            return MAX_MIN_LEN;
        end
        return 32'(v);
    endfunction

    function automatic void push_bit(bit b);
        result_t r;
        if (burst.size() < MAX_BURST)
        begin
            r.out_map  = cur_map;
            r.out_bin  = cur_bin;
            r.filtered = b;
            r.last     = 1'b0;
            burst = {burst, r};
        end
    endfunction

    // drop one runs shorter than pulse_len
    function automatic void pulse_stage(int s, bit b);
        if (b)
        begin
            if (trk[s].one_run_ok)
            begin
                push_bit(1'b1);
            end
            else
            begin
                trk[s].ones_held++;
                if (trk[s].ones_held >= clamp_len(pulse_len))
                begin
                    repeat (trk[s].ones_held) push_bit(1'b1);
                    trk[s].ones_held  = 0;
                    trk[s].one_run_ok = 1'b1;
                end
            end
        end
        else
        begin
            repeat (trk[s].ones_held) push_bit(1'b0);
            trk[s].ones_held  = 0;
            trk[s].one_run_ok = 1'b0;
            push_bit(1'b0);
        end
    endfunction

    // fill zero gaps shorter than gap_len
    function automatic void gap_stage(int s, bit b);
        int unsigned n;
        if (!b)
        begin
            if (trk[s].zero_run_ok)
            begin
                pulse_stage(s, 1'b0);
            end
            else
            begin
                trk[s].zeros_held++;
                if (trk[s].zeros_held >= clamp_len(gap_len))
                begin
                    n = trk[s].zeros_held;
                    trk[s].zeros_held  = 0;
                    trk[s].zero_run_ok = 1'b1;
                    repeat (n) pulse_stage(s, 1'b0);
                end
            end
        end
        else
        begin
            n = trk[s].zeros_held;
            trk[s].zeros_held  = 0;
            trk[s].zero_run_ok = 1'b0;
            repeat (n) pulse_stage(s, 1'b1);
            pulse_stage(s, 1'b1);
        end
    endfunction

    function automatic void predict_sample(sample_t it);
        int          s;
        int unsigned n;
        s       = int'({it.map_select, it.bin_index});
        cur_map = it.map_select;
        cur_bin = it.bin_index;
        burst.delete();
        gap_stage(s, it.active);
        if (it.frame_last)
        begin
            // held zeros close as ones, then held ones open as zeros
            n = trk[s].zeros_held;
            trk[s].zeros_held = 0;
            repeat (n) pulse_stage(s, 1'b1);
            n = trk[s].ones_held;
            trk[s].ones_held = 0;
            repeat (n) push_bit(1'b0);
            trk[s] = '{default: 0};
        end
        if (burst.size() > 0)
        begin
            burst[$].last = 1'b1;
        end
        foreach (burst[i]) filt_q = {filt_q, burst[i]};
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void add_sample(bit m, int b, bit a, bit f);
        sample_t it;
        it.map_select = m;
        it.bin_index  = BIN_W'(b);
        it.active     = a;
        it.frame_last = f;
        next_q = {next_q, it};
    endfunction

    function automatic int pick_run();
        int top;
        top = (clamp_len(gap_len) > clamp_len(pulse_len)) ? clamp_len(gap_len)
                                                           : clamp_len(pulse_len);
        if ($urandom_range(9) == 0)
        begin
            return $urandom_range(20, 1);
        end
        return $urandom_range(top + 2, 1);
    endfunction

    function automatic void new_lane(int i);
        lanes[i].map   = 1'($urandom_range(1));
        lanes[i].bin   = BIN_W'($urandom_range(127));
        lanes[i].level = 1'($urandom_range(1));
        lanes[i].left  = pick_run();
    endfunction

    function automatic void gen_random(int count);
        sample_t it;
        int      i;
        repeat (count)
        begin
            if ($urandom_range(99) < 15)
            begin
                it.map_select = 1'($urandom_range(1));
                it.bin_index  = BIN_W'($urandom_range(127));
                it.active     = 1'($urandom_range(1));
                it.frame_last = ($urandom_range(7) == 0);
            end
            else
            begin
                i = $urandom_range(NUM_LANES - 1);
                it.map_select = lanes[i].map;
                it.bin_index  = lanes[i].bin;
                it.active     = lanes[i].level;
                it.frame_last = ($urandom_range(29) == 0);
                if (it.frame_last)
                begin
                    new_lane(i);
                end
                else
                begin
                    lanes[i].left--;
                    if (lanes[i].left <= 0)
                    begin
                        lanes[i].level = !lanes[i].level;
                        lanes[i].left  = pick_run();
                    end
                end
            end
            next_q = {next_q, it};
        end
    endfunction

    function automatic void add_directed();
        // leading short gap, confirmed gap, frame end on a one
        repeat (3) add_sample(1'b0, 0, 1'b0, 1'b0);
        add_sample(1'b0, 0, 1'b1, 1'b0);
        repeat (4) add_sample(1'b0, 0, 1'b0, 1'b0);
        add_sample(1'b0, 0, 1'b1, 1'b0);
        add_sample(1'b0, 0, 1'b1, 1'b1);
        // short pulse cut by frame end
        add_sample(1'b1, 127, 1'b1, 1'b0);
        add_sample(1'b1, 127, 1'b1, 1'b0);
        add_sample(1'b1, 127, 1'b0, 1'b1);
        // single-sample frames
        add_sample(1'b1, 127, 1'b1, 1'b1);
        add_sample(1'b1, 85, 1'b1, 1'b1);
        add_sample(1'b0, 42, 1'b0, 1'b1);
        // trailing short gap closed at frame end
        add_sample(1'b0, 3, 1'b1, 1'b0);
        add_sample(1'b0, 3, 1'b0, 1'b0);
        add_sample(1'b0, 3, 1'b0, 1'b1);
    endfunction

    // 15 held ones, 15 held zeros, then a one: the largest burst (needs 16/16)
    function automatic void add_max_burst();
        add_sample(1'b1, 99, 1'b0, 1'b1);
        repeat (15) add_sample(1'b1, 99, 1'b1, 1'b0);
        repeat (15) add_sample(1'b1, 99, 1'b0, 1'b0);
        add_sample(1'b1, 99, 1'b1, 1'b1);
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                predict_sample(sample);
            end
            if (!sample_valid || !sample_stall)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    sample       <= sample_q.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            // a new phase brings its own hold-off length
            if (hold_phase != phase_num)
            begin
                hold_phase = phase_num;
                hold_left  = hold_ask;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic check_field(string name, int got, int exp_val);
        if (got != exp_val)
        begin
            report_error($sformatf("%s mismatch: got %0d, expected %0d (map %0d bin %0d)",
                                   name, got, exp_val, want.out_map, want.out_bin));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (filt_q.size() == 0)
            begin
                report_error($sformatf("unexpected result map %0d bin %0d bit %0d",
                                       result.out_map, result.out_bin, result.filtered));
            end
            else
            begin
                want = filt_q.pop_front();
                check_field("out_map", int'(result.out_map), int'(want.out_map));
                check_field("out_bin", int'(result.out_bin), int'(want.out_bin));
                check_field("filtered", int'(result.filtered), int'(want.filtered));
                check_field("last", int'(result.last), int'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequencing

    task automatic configure(logic [LEN_W-1:0] gap, logic [LEN_W-1:0] pulse);
        cfg_valid <= 1'b1;
        cfg_index <= REG_GAP_MIN_LEN;
        cfg_data  <= gap;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        gap_len = gap;
        cfg_index <= REG_PULSE_MIN_LEN;
        cfg_data  <= pulse;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        pulse_len = pulse;
        cfg_valid <= 1'b0;
    endtask

    // knobs and queue change away from the active edge
    task automatic begin_phase(int idle, int stall, int hold);
        @(negedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        hold_ask  = hold;
        phase_num++;
        foreach (next_q[i]) sample_q = {sample_q, next_q[i]};
        next_q.delete();
    endtask

    task automatic drain();
        @(posedge clk);
        while (sample_q.size() != 0 || sample_valid || filt_q.size() != 0) @(posedge clk);
    endtask

    task automatic run_phase(logic [LEN_W-1:0] gap, logic [LEN_W-1:0] pulse,
                             int idle, int stall, int count, int hold, bit with_max);
        // a sample with no result may still be in flight
        repeat (SETTLE_CYC) @(posedge clk);
        configure(gap, pulse);
        if (with_max)
        begin
            add_max_burst();
        end
        gen_random(count);
        begin_phase(idle, stall, hold);
        drain();
    endtask

    initial
    begin
        foreach (trk[i]) trk[i] = '{default: 0};
        foreach (lanes[i]) new_lane(i);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        add_directed();
        begin_phase(0, 0, 0);
        drain();

        run_phase(LEN_W'(1),  LEN_W'(1),  51, 0,  48, 0,        1'b0);
        run_phase(LEN_W'(16), LEN_W'(16), 0,  51, 48, 0,        1'b1);
        run_phase(LEN_W'(0),  LEN_W'(31), 9,  9,  48, 0,        1'b0);
        run_phase(LEN_W'(3),  LEN_W'(5),  0,  0,  48, HOLD_CYC, 1'b0);
        run_phase(LEN_W'(2),  LEN_W'(7),  51, 0,  40, 0,        1'b0);
        run_phase(LEN_W'(17), LEN_W'(0),  0,  51, 40, 0,        1'b0);

        repeat (END_WAIT_CYC) @(posedge clk);
        if (filt_q.size() != 0)
        begin
            report_error($sformatf("%0d expected results never arrived", filt_q.size()));
        end
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* binary_gap_fill_pulse_filter_core.f */
+incdir+sv
sv/bgf_pkg.sv
sv/bgf_ram.sv
sv/bgf_update.sv
sv/bgf_emitter.sv
sv/binary_gap_fill_pulse_filter_core.sv
dv/binary_gap_fill_pulse_filter_core_test.sv
